// ----- rtl/cit_pkg.sv -----
// ----------------------------------------------------------------------------
// cit_pkg
// Shared widths, register indexes and entry types of the identifier tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package cit_pkg;

	// field widths
	localparam int ID_W    = 29;
	localparam int LEN_W   = 4;
	localparam int DATA_W  = 64;
	localparam int STAMP_W = 48;
	localparam int COUNT_W = 32;
	localparam int NBYTES  = 8;

	// default sizes
	localparam int TABLE_DEPTH_DEF = 64;
	localparam int RING_DEPTH_DEF  = 1024;

	// configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_OVERWRITE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_SESSION   = 1'b1;

	// one table entry as held in the entry memory
	typedef struct packed {
		logic [LEN_W-1:0]   length;
		logic [DATA_W-1:0]  bytes;
		logic [COUNT_W-1:0] count;
		logic               fresh;
	} entry_t;

	// per-frame table verdict
	typedef struct packed {
		logic               inserted;
		logic               still_new;
		logic               length_changed;
		logic [NBYTES-1:0]  byte_mask;
		logic               content_changed;
		logic [COUNT_W-1:0] seen_count;
		logic               table_full;
	} upd_res_t;

endpackage

`default_nettype wire

// ----- rtl/cit_ram.sv -----
// ----------------------------------------------------------------------------
// cit_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module cit_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read, old data on a same-address write
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ----- rtl/cit_key_cam.sv -----
// ----------------------------------------------------------------------------
// cit_key_cam
// Identifier store with parallel compare, slot encode and insert bypass.
// ----------------------------------------------------------------------------
`default_nettype none

module cit_key_cam #(
	parameter int TABLE_DEPTH = cit_pkg::TABLE_DEPTH_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic [cit_pkg::ID_W-1:0]       lookup_id,
	input  wire logic                           byp_valid,
	input  wire logic [cit_pkg::ID_W-1:0]       byp_id,
	input  wire logic [$clog2(TABLE_DEPTH)-1:0] byp_slot,
	input  wire logic                           wr_en,
	input  wire logic [$clog2(TABLE_DEPTH)-1:0] wr_slot,
	input  wire logic [cit_pkg::ID_W-1:0]       wr_id,
	output logic                                hit,
	output logic      [$clog2(TABLE_DEPTH)-1:0] hit_slot
);

	import cit_pkg::*;

	localparam int SLOT_W = $clog2(TABLE_DEPTH);

	logic [ID_W-1:0]        key_q [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] valid_q;
	logic [TABLE_DEPTH-1:0] match;

	// key storage
	always_ff @(posedge clk) begin
		if (wr_en) begin
			key_q[wr_slot] <= wr_id;
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[wr_slot] <= 1'b1;
		end
	end

	// compare every slot, keys are unique so at most one matches
	always_comb begin
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			match[i] = valid_q[i] && (key_q[i] == lookup_id);
		end
	end

	// encode, with the entry being inserted this cycle taking part
	always_comb begin
		hit      = |match;
		hit_slot = '0;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			if (match[i]) begin
				hit_slot = hit_slot | SLOT_W'(i);
			end
		end
		if (byp_valid && (byp_id == lookup_id)) begin
			hit      = 1'b1;
			hit_slot = byp_slot;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/cit_update.sv -----
// ----------------------------------------------------------------------------
// cit_update
// Byte compare, entry update and insert decision for one frame.
// ----------------------------------------------------------------------------
`default_nettype none

module cit_update #(
	parameter int TABLE_DEPTH = cit_pkg::TABLE_DEPTH_DEF
) (
	input  wire logic                             hit,
	input  wire logic [$clog2(TABLE_DEPTH)-1:0]   hit_slot,
	input  wire logic [$clog2(TABLE_DEPTH+1)-1:0] used,
	input  wire logic [cit_pkg::LEN_W-1:0]        len,
	input  wire logic [cit_pkg::DATA_W-1:0]       data,
	input  wire cit_pkg::entry_t                  old_entry,
	output logic                                  ent_wr,
	output logic                                  key_wr,
	output logic      [$clog2(TABLE_DEPTH)-1:0]   wr_slot,
	output cit_pkg::entry_t                       new_entry,
	output logic      [$clog2(TABLE_DEPTH)-1:0]   res_slot,
	output cit_pkg::upd_res_t                     res
);

	import cit_pkg::*;

	localparam int SLOT_W = $clog2(TABLE_DEPTH);
	localparam int USED_W = $clog2(TABLE_DEPTH+1);

	logic [LEN_W-1:0]   n_bytes;
	logic [NBYTES-1:0]  sel;
	logic [NBYTES-1:0]  mask;
	logic               len_chg;
	logic               chg;
	logic               free;
	logic               ins;
	logic [DATA_W-1:0]  bytes_nxt;
	logic [COUNT_W-1:0] count_nxt;

	// bytes in use and per-byte compare
	always_comb begin
		n_bytes = (len > LEN_W'(NBYTES)) ? LEN_W'(NBYTES) : len;
		for (int b = 0; b < NBYTES; b++) begin
			sel[b]  = LEN_W'(b) < n_bytes;
			mask[b] = sel[b] && ((LEN_W'(b) >= old_entry.length) ||
				(data[8*b +: 8] != old_entry.bytes[8*b +: 8]));
			if (sel[b]) begin
				bytes_nxt[8*b +: 8] = data[8*b +: 8];
			end else if (hit) begin
				bytes_nxt[8*b +: 8] = old_entry.bytes[8*b +: 8];
			end else begin
				bytes_nxt[8*b +: 8] = 8'h00;
			end
		end
		len_chg = len != old_entry.length;
		chg     = len_chg || (|mask);
	end

	// saturating frame count
	assign count_nxt = (old_entry.count == '1) ? old_entry.count
		: old_entry.count + COUNT_W'(1);

	// insert on a miss while a slot is free
	assign free    = used < USED_W'(TABLE_DEPTH);
	assign ins     = !hit && free;
	assign ent_wr  = hit || ins;
	assign key_wr  = ins;
	assign wr_slot = hit ? hit_slot : used[SLOT_W-1:0];

	// new entry contents
	always_comb begin
		new_entry.length = len;
		new_entry.bytes  = bytes_nxt;
		if (hit) begin
			new_entry.count = count_nxt;
			new_entry.fresh = old_entry.fresh && !chg;
		end else begin
			new_entry.count = COUNT_W'(1);
			new_entry.fresh = 1'b1;
		end
	end

	// verdict, all zero but table_full on a full table
	always_comb begin
		res_slot            = ent_wr ? wr_slot : '0;
		res.inserted        = ins;
		res.still_new       = ent_wr && new_entry.fresh;
		res.length_changed  = hit && len_chg;
		res.byte_mask       = hit ? mask : '0;
		res.content_changed = hit && chg;
		res.seen_count      = ent_wr ? new_entry.count : '0;
		res.table_full      = !hit && !free;
	end

endmodule

`default_nettype wire

// ----- rtl/can_id_change_tracker.sv -----
// ----------------------------------------------------------------------------
// can_id_change_tracker
// Tracks CAN identifiers and reports per-byte payload changes per frame.
// ----------------------------------------------------------------------------
// Usage:
//   in channel  : one frame per transaction (frame_id, length_code, payload,
//                 stamp_us), valid/ready.
//   out channel : one verdict per frame, in frame order, valid/ready.
//   cfg channel : cfg_index/cfg_data write, always ready; write only while
//                 no frame is in flight.
// Timing:
//   a frame passes an input stage (identifier compare across all table
//   slots, entry memory read) and an update stage (byte compare, entry
//   write-back) and lands in the output register, which holds its verdict.
//   One frame is taken per cycle while the verdict channel does not stall; a frame
//   following one on the same identifier gets the updated entry forwarded.
// Reset: table empty, capture ring empty, overwrite enabled, session start
//   zero. No clearing pass is needed.
// Stall: a held verdict blocks the update stage; the input stage and the
//   input channel keep taking frames until both stages are full.
// ----------------------------------------------------------------------------
`default_nettype none

module can_id_change_tracker #(
	parameter int TABLE_DEPTH = cit_pkg::TABLE_DEPTH_DEF,
	parameter int RING_DEPTH  = cit_pkg::RING_DEPTH_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// configuration
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [cit_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [cit_pkg::STAMP_W-1:0]    cfg_data,
	// frames in
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic [cit_pkg::ID_W-1:0]       frame_id,
	input  wire logic [cit_pkg::LEN_W-1:0]      length_code,
	input  wire logic [cit_pkg::DATA_W-1:0]     payload,
	input  wire logic [cit_pkg::STAMP_W-1:0]    stamp_us,
	// verdicts out
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic      [$clog2(TABLE_DEPTH)-1:0] entry_slot,
	output logic                                inserted,
	output logic                                still_new,
	output logic                                length_changed,
	output logic      [cit_pkg::NBYTES-1:0]     byte_changed_mask,
	output logic                                content_changed,
	output logic      [cit_pkg::COUNT_W-1:0]    seen_count,
	output logic      [cit_pkg::STAMP_W-1:0]    relative_us,
	output logic                                ring_stored,
	output logic                                ring_full,
	output logic                                table_full
);

	import cit_pkg::*;

	localparam int SLOT_W  = $clog2(TABLE_DEPTH);
	localparam int USED_W  = $clog2(TABLE_DEPTH+1);
	localparam int RFILL_W = $clog2(RING_DEPTH+1);
	localparam int ENT_W   = $bits(entry_t);

	// configuration registers
	logic               ovw_q;
	logic [STAMP_W-1:0] session_q;

	// input stage
	logic               valid_s1;
	logic [ID_W-1:0]    id_s1;
	logic [LEN_W-1:0]   len_s1;
	logic [DATA_W-1:0]  data_s1;
	logic [STAMP_W-1:0] stamp_s1;

	// update stage
	logic               valid_s2;
	logic [ID_W-1:0]    id_s2;
	logic [LEN_W-1:0]   len_s2;
	logic [DATA_W-1:0]  data_s2;
	logic [STAMP_W-1:0] stamp_s2;
	logic               hit_s2;
	logic [SLOT_W-1:0]  slot_s2;
	logic               fwd_s2;
	entry_t             fwd_entry_s2;

	// output register
	logic               out_valid_q;
	logic [SLOT_W-1:0]  slot_q;
	upd_res_t           res_q;
	logic [STAMP_W-1:0] rel_q;
	logic               stored_q;
	logic               rfull_q;

	// table and ring state
	logic [USED_W-1:0]  used_q;
	logic [RFILL_W-1:0] fill_q;

	// internal nets
	logic               fire_s2;
	logic               adv_s1;
	logic               cam_hit;
	logic [SLOT_W-1:0]  cam_slot;
	logic [ENT_W-1:0]   ram_rd;
	entry_t             old_entry;
	logic               ent_wr;
	logic               key_wr;
	logic [SLOT_W-1:0]  wr_slot;
	entry_t             new_entry;
	logic [SLOT_W-1:0]  upd_slot;
	upd_res_t           upd_res;
	logic               rfull_now;
	logic               stored;
	logic [RFILL_W-1:0] fill_nxt;
	logic [STAMP_W-1:0] rel;

	// handshake control
	assign fire_s2   = valid_s2 && (!out_valid_q || out_ready);
	assign adv_s1    = valid_s1 && (!valid_s2 || fire_s2);
	assign in_ready  = !valid_s1 || !valid_s2 || fire_s2;
	assign cfg_ready = 1'b1;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovw_q     <= 1'b1;
			session_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_OVERWRITE: ovw_q     <= cfg_data[0];
				REG_SESSION:   session_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// input stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// input stage payload
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			id_s1    <= frame_id;
			len_s1   <= length_code;
			data_s1  <= payload;
			stamp_s1 <= stamp_us;
		end
	end

	// identifier lookup
	cit_key_cam #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_cam (
		.clk      (clk),
		.arst_n   (arst_n),
		.lookup_id(id_s1),
		.byp_valid(valid_s2 && key_wr),
		.byp_id   (id_s2),
		.byp_slot (wr_slot),
		.wr_en    (fire_s2 && key_wr),
		.wr_slot  (wr_slot),
		.wr_id    (id_s2),
		.hit      (cam_hit),
		.hit_slot (cam_slot)
	);

	// entry memory
	cit_ram #(
		.WIDTH(ENT_W),
		.DEPTH(TABLE_DEPTH)
	) u_entry_ram (
		.clk    (clk),
		.wr_en  (fire_s2 && ent_wr),
		.wr_addr(wr_slot),
		.wr_data(new_entry),
		.rd_en  (adv_s1),
		.rd_addr(cam_slot),
		.rd_data(ram_rd)
	);

	// update stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || fire_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	// update stage payload, forward an entry written at the same edge
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			id_s2        <= id_s1;
			len_s2       <= len_s1;
			data_s2      <= data_s1;
			stamp_s2     <= stamp_s1;
			hit_s2       <= cam_hit;
			slot_s2      <= cam_slot;
			fwd_s2       <= fire_s2 && ent_wr && cam_hit && (cam_slot == wr_slot);
			fwd_entry_s2 <= new_entry;
		end
	end

	assign old_entry = fwd_s2 ? fwd_entry_s2 : entry_t'(ram_rd);

	// compare and update
	cit_update #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_update (
		.hit      (hit_s2),
		.hit_slot (slot_s2),
		.used     (used_q),
		.len      (len_s2),
		.data     (data_s2),
		.old_entry(old_entry),
		.ent_wr   (ent_wr),
		.key_wr   (key_wr),
		.wr_slot  (wr_slot),
		.new_entry(new_entry),
		.res_slot (upd_slot),
		.res      (upd_res)
	);

	// capture ring occupancy and relative time
	assign rfull_now = fill_q == RFILL_W'(RING_DEPTH);
	assign stored    = !rfull_now || ovw_q;
	assign fill_nxt  = (stored && !rfull_now) ? fill_q + RFILL_W'(1) : fill_q;
	assign rel       = (stamp_s2 >= session_q) ? stamp_s2 - session_q : '0;

	// table fill and ring counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			fill_q <= '0;
		end else if (fire_s2) begin
			if (key_wr) begin
				used_q <= used_q + USED_W'(1);
			end
			fill_q <= fill_nxt;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || out_ready) begin
			out_valid_q <= valid_s2;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (fire_s2) begin
			slot_q   <= upd_slot;
			res_q    <= upd_res;
			rel_q    <= rel;
			stored_q <= stored;
			rfull_q  <= fill_nxt == RFILL_W'(RING_DEPTH);
		end
	end

	// result ports
	assign out_valid         = out_valid_q;
	assign entry_slot        = slot_q;
	assign inserted          = res_q.inserted;
	assign still_new         = res_q.still_new;
	assign length_changed    = res_q.length_changed;
	assign byte_changed_mask = res_q.byte_mask;
	assign content_changed   = res_q.content_changed;
	assign seen_count        = res_q.seen_count;
	assign relative_us       = rel_q;
	assign ring_stored       = stored_q;
	assign ring_full         = rfull_q;
	assign table_full        = res_q.table_full;

	// checks
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= USED_W'(TABLE_DEPTH))
		else $error("table fill count beyond table depth");

	a_used_step: assert property (@(posedge clk) disable iff (!arst_n)
		fire_s2 && key_wr |=> used_q == $past(used_q) + USED_W'(1))
		else $error("insert did not advance table fill count");

	a_ins_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(res_q.inserted && res_q.table_full))
		else $error("frame both inserted and rejected");

	a_fresh_chg: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.content_changed |-> !res_q.still_new)
		else $error("changed entry still marked new");

	a_fwd_hit: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && fwd_s2 |-> hit_s2)
		else $error("entry forwarded to a missing frame");

	a_full_used: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.table_full |-> used_q == USED_W'(TABLE_DEPTH))
		else $error("table full reported with free slots");

endmodule

`default_nettype wire

// ----- tb/can_id_tracker_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// can_id_tracker_checker
// Watches the configuration, frame and verdict channels of the identifier
// tracker, predicts the verdict of every accepted frame from its own copy of
// the identifier table and ring fill, and compares each verdict field by field.
// ----------------------------------------------------------------------------

module can_id_tracker_checker #(
	parameter int TABLE_DEPTH = cit_pkg::TABLE_DEPTH_DEF,
	parameter int RING_DEPTH  = cit_pkg::RING_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [cit_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cit_pkg::STAMP_W-1:0]    cfg_data,
	input  logic                           in_valid,
	input  logic                           in_ready,
	input  logic [cit_pkg::ID_W-1:0]       frame_id,
	input  logic [cit_pkg::LEN_W-1:0]      length_code,
	input  logic [cit_pkg::DATA_W-1:0]     payload,
	input  logic [cit_pkg::STAMP_W-1:0]    stamp_us,
	input  logic                           out_valid,
	input  logic                           out_ready,
	input  logic [$clog2(TABLE_DEPTH)-1:0] entry_slot,
	input  logic                           inserted,
	input  logic                           still_new,
	input  logic                           length_changed,
	input  logic [cit_pkg::NBYTES-1:0]     byte_changed_mask,
	input  logic                           content_changed,
	input  logic [cit_pkg::COUNT_W-1:0]    seen_count,
	input  logic [cit_pkg::STAMP_W-1:0]    relative_us,
	input  logic                           ring_stored,
	input  logic                           ring_full,
	input  logic                           table_full,
	output int                             fail_count,
	output int                             pending
);

	import cit_pkg::*;

	localparam int SLOT_W   = $clog2(TABLE_DEPTH);
	localparam int VQ_DEPTH = 16;

	// one predicted verdict
	typedef struct packed {
		logic [SLOT_W-1:0]  slot;
		logic               inserted;
		logic               still_new;
		logic               length_changed;
		logic [NBYTES-1:0]  byte_mask;
		logic               content_changed;
		logic [COUNT_W-1:0] seen_count;
		logic [STAMP_W-1:0] relative_us;
		logic               ring_stored;
		logic               ring_full;
		logic               table_full;
	} verdict_t;

	// configuration copy
	logic               overwrite_on;
	logic [STAMP_W-1:0] session_origin;

	// identifier table copy
	logic               trk_valid [TABLE_DEPTH];
	logic [ID_W-1:0]    trk_key   [TABLE_DEPTH];
	logic [LEN_W-1:0]   trk_len   [TABLE_DEPTH];
	logic [DATA_W-1:0]  trk_bytes [TABLE_DEPTH];
	logic [COUNT_W-1:0] trk_count [TABLE_DEPTH];
	logic               trk_fresh [TABLE_DEPTH];
	int                 used_slots;

	// only the ring fill level is visible in the verdicts
	int                 ring_count;

	// predicted verdicts waiting for their transaction, oldest at vq_rd
	verdict_t           verdict_buf [VQ_DEPTH];
	int                 vq_wr;
	int                 vq_rd;
	verdict_t           want;

	// verdict of one frame, updating the ring fill and the table
	function automatic verdict_t track_frame(input logic [ID_W-1:0] id,
			input logic [LEN_W-1:0] len, input logic [DATA_W-1:0] data,
			input logic [STAMP_W-1:0] stamp);
		verdict_t v;
		int nb;
		int hit;
		int s;
		logic [DATA_W-1:0] keep;
		v = '0;
		nb = int'(len);
		if (nb > NBYTES)
			nb = NBYTES;
		keep = (nb == NBYTES) ? '1 : ((64'd1 << (8 * nb)) - 64'd1);
		v.relative_us = (stamp >= session_origin) ? stamp - session_origin : '0;

		// capture ring: a full ring drops the frame unless overwrite is on
		if (ring_count < RING_DEPTH || overwrite_on) begin
			v.ring_stored = 1'b1;
			if (ring_count < RING_DEPTH)
				ring_count++;
		end
		v.ring_full = (ring_count >= RING_DEPTH);

		// lookup, first matching slot wins
		hit = -1;
		for (s = 0; s < used_slots; s++)
			if (hit < 0 && trk_valid[s] && trk_key[s] == id)
				hit = s;

		if (hit >= 0) begin
			// hit: bytes past the stored length always count as changed
			v.length_changed = (len != trk_len[hit]);
			for (s = 0; s < nb; s++)
				if (s >= int'(trk_len[hit]) ||
						data[8*s +: 8] != trk_bytes[hit][8*s +: 8])
					v.byte_mask[s] = 1'b1;
			v.content_changed = v.length_changed || (v.byte_mask != '0);
			if (v.content_changed) begin
				trk_fresh[hit] = 1'b0;
				trk_len[hit] = len;
				trk_bytes[hit] = (trk_bytes[hit] & ~keep) | (data & keep);
			end
			if (trk_count[hit] != '1)
				trk_count[hit]++;
			v.slot = SLOT_W'(hit);
			v.still_new = trk_fresh[hit];
			v.seen_count = trk_count[hit];
		end else if (used_slots < TABLE_DEPTH) begin
			// miss with room: new entry, unused bytes zeroed
			trk_valid[used_slots] = 1'b1;
			trk_key[used_slots] = id;
			trk_len[used_slots] = len;
			trk_bytes[used_slots] = data & keep;
			trk_count[used_slots] = COUNT_W'(1);
			trk_fresh[used_slots] = 1'b1;
			v.slot = SLOT_W'(used_slots);
			v.inserted = 1'b1;
			v.still_new = 1'b1;
			v.seen_count = COUNT_W'(1);
			used_slots++;
		end else begin
			v.table_full = 1'b1;
		end
		return v;
	endfunction

	task automatic compare_field(input string field, input logic [63:0] exp_val,
			input logic [63:0] act_val);
		if (act_val !== exp_val) begin
			$error("%s: expected %0h, got %0h", field, exp_val, act_val);
			fail_count++;
		end
	endtask

	// channel monitor: configuration, then frames, then verdicts
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			overwrite_on = 1'b1;
			session_origin = '0;
			for (int s = 0; s < TABLE_DEPTH; s++)
				trk_valid[s] = 1'b0;
			used_slots = 0;
			ring_count = 0;
			vq_wr = 0;
			vq_rd = 0;
			pending = 0;
			fail_count = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_OVERWRITE: overwrite_on = cfg_data[0];
					REG_SESSION:   session_origin = cfg_data;
					default:       ;
				endcase
			end
			if (in_valid && in_ready) begin
				if (vq_wr - vq_rd >= VQ_DEPTH) begin
					$error("more frames in flight than the checker can hold");
					fail_count++;
				end
				verdict_buf[vq_wr % VQ_DEPTH] =
					track_frame(frame_id, length_code, payload, stamp_us);
				vq_wr++;
			end
			if (out_valid && out_ready) begin
				if (vq_wr == vq_rd) begin
					$error("verdict transaction with no frame waiting");
					fail_count++;
				end else begin
					want = verdict_buf[vq_rd % VQ_DEPTH];
					vq_rd++;
					compare_field("entry_slot", 64'(want.slot), 64'(entry_slot));
					compare_field("inserted", 64'(want.inserted), 64'(inserted));
					compare_field("still_new", 64'(want.still_new), 64'(still_new));
					compare_field("length_changed", 64'(want.length_changed),
						64'(length_changed));
					compare_field("byte_changed_mask", 64'(want.byte_mask),
						64'(byte_changed_mask));
					compare_field("content_changed", 64'(want.content_changed),
						64'(content_changed));
					compare_field("seen_count", 64'(want.seen_count), 64'(seen_count));
					compare_field("relative_us", 64'(want.relative_us), 64'(relative_us));
					compare_field("ring_stored", 64'(want.ring_stored), 64'(ring_stored));
					compare_field("ring_full", 64'(want.ring_full), 64'(ring_full));
					compare_field("table_full", 64'(want.table_full), 64'(table_full));
				end
			end
			pending = vq_wr - vq_rd;
		end
	end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Frame stimulus for the identifier tracker: directed frames on the edges of
// every field, then random traffic on a pool of recurring identifiers with
// repeated, partly changed and fresh payloads across several configurations,
// long enough to fill the table, under both overwrite settings. Bursty
// sender, patterned verdict stalls, no-progress watchdog.
// ----------------------------------------------------------------------------

module tb;
	import cit_pkg::*;

	localparam int TABLE_DEPTH    = TABLE_DEPTH_DEF;
	localparam int RING_DEPTH     = RING_DEPTH_DEF;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int POOL_MAX       = 96;
	localparam logic [ID_W-1:0]    ID_MAX    = '1;
	localparam logic [STAMP_W-1:0] STAMP_MAX = '1;
	localparam logic [DATA_W-1:0]  BYTES_ALL = '1;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           cfg_valid;
	logic                           cfg_ready;
	logic [CFG_IDX_W-1:0]           cfg_index;
	logic [STAMP_W-1:0]             cfg_data;
	logic                           in_valid;
	logic                           in_ready;
	logic [ID_W-1:0]                frame_id;
	logic [LEN_W-1:0]               length_code;
	logic [DATA_W-1:0]              payload;
	logic [STAMP_W-1:0]             stamp_us;
	logic                           out_valid;
	logic                           out_ready = 1'b0;
	logic [$clog2(TABLE_DEPTH)-1:0] entry_slot;
	logic                           inserted;
	logic                           still_new;
	logic                           length_changed;
	logic [NBYTES-1:0]              byte_changed_mask;
	logic                           content_changed;
	logic [COUNT_W-1:0]             seen_count;
	logic [STAMP_W-1:0]             relative_us;
	logic                           ring_stored;
	logic                           ring_full;
	logic                           table_full;

	int                             fail_count;
	int                             pending;

	// stimulus state
	int                             burst_left = 0;
	logic [STAMP_W-1:0]             cur_session = '0;
	logic [ID_W-1:0]                pool_id   [POOL_MAX];
	logic [LEN_W-1:0]               pool_len  [POOL_MAX];
	logic [DATA_W-1:0]              pool_data [POOL_MAX];
	int                             ready_span = 0;
	logic [15:0]                    ready_bits = '1;
	int                             quiet_cycles = 0;

	always #4 clk = ~clk;

	can_id_change_tracker #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.RING_DEPTH  (RING_DEPTH)
	) uut (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.frame_id          (frame_id),
		.length_code       (length_code),
		.payload           (payload),
		.stamp_us          (stamp_us),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.entry_slot        (entry_slot),
		.inserted          (inserted),
		.still_new         (still_new),
		.length_changed    (length_changed),
		.byte_changed_mask (byte_changed_mask),
		.content_changed   (content_changed),
		.seen_count        (seen_count),
		.relative_us       (relative_us),
		.ring_stored       (ring_stored),
		.ring_full         (ring_full),
		.table_full        (table_full)
	);

	can_id_tracker_checker #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.RING_DEPTH  (RING_DEPTH)
	) checker_i (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.frame_id          (frame_id),
		.length_code       (length_code),
		.payload           (payload),
		.stamp_us          (stamp_us),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.entry_slot        (entry_slot),
		.inserted          (inserted),
		.still_new         (still_new),
		.length_changed    (length_changed),
		.byte_changed_mask (byte_changed_mask),
		.content_changed   (content_changed),
		.seen_count        (seen_count),
		.relative_us       (relative_us),
		.ring_stored       (ring_stored),
		.ring_full         (ring_full),
		.table_full        (table_full),
		.fail_count        (fail_count),
		.pending           (pending)
	);

	// verdict receiver: rotating stall pattern, reloaded now and then
	always @(negedge clk) begin
		if (ready_span == 0) begin
			ready_span <= $urandom_range(16, 96);
			if ($urandom_range(0, 3) == 0)
				ready_bits <= 16'hFFFF;
			else
				ready_bits <= 16'($urandom_range(0, 65535)) | 16'd1;
		end else begin
			ready_span <= ready_span - 1;
			ready_bits <= {ready_bits[14:0], ready_bits[15]};
		end
		out_ready <= ready_bits[0];
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end

	// one frame transaction, with a random gap at the start of each burst
	task automatic send_frame(input logic [ID_W-1:0] id, input logic [LEN_W-1:0] len,
			input logic [DATA_W-1:0] data, input logic [STAMP_W-1:0] stamp);
		int idle;
		@(negedge clk);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			idle = $urandom_range(0, 5);
			if (idle != 0) begin
				in_valid <= 1'b0;
				repeat (idle) @(negedge clk);
			end
		end
		burst_left--;
		frame_id <= id;
		length_code <= len;
		payload <= data;
		stamp_us <= stamp;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
	endtask

	// stop sending and wait until every verdict is back
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		burst_left = 0;
		while (pending != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [STAMP_W-1:0] val);
		@(negedge clk);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		if (idx == REG_SESSION)
			cur_session = val;
	endtask

	// half fully random, half close around the session start
	function automatic logic [STAMP_W-1:0] pick_stamp();
		logic [STAMP_W-1:0] offset;
		if ($urandom_range(0, 1) == 0)
			return STAMP_W'({$urandom, $urandom});
		offset = STAMP_W'($urandom_range(0, 2000));
		return cur_session + offset - 48'd1000;
	endfunction

	// new identifiers, some one bit away from their neighbor
	task automatic build_pool(input int first, input int last);
		for (int k = first; k < last; k++) begin
			if (k > 0 && $urandom_range(0, 4) == 0)
				pool_id[k] = pool_id[k-1] ^ (29'd1 << $urandom_range(0, ID_W - 1));
			else
				pool_id[k] = ID_W'($urandom);
			pool_len[k] = LEN_W'($urandom_range(0, 15));
			pool_data[k] = {$urandom, $urandom};
		end
	endtask

	// mostly recurring identifiers with repeated or partly changed content
	task automatic send_tracked(input int pool_size);
		int k;
		int sel;
		k = $urandom_range(0, pool_size - 1);
		sel = $urandom_range(0, 99);
		if (sel >= 92) begin
			send_frame(ID_W'($urandom), LEN_W'($urandom_range(0, 15)),
				{$urandom, $urandom}, pick_stamp());
		end else begin
			if (sel >= 45 && sel < 70)
				pool_data[k][8*$urandom_range(0, 7) +: 8] = 8'($urandom);
			else if (sel >= 70 && sel < 82)
				pool_len[k] = LEN_W'($urandom_range(0, 15));
			else if (sel >= 82) begin
				pool_len[k] = LEN_W'($urandom_range(0, 15));
				pool_data[k] = {$urandom, $urandom};
			end
			send_frame(pool_id[k], pool_len[k], pool_data[k], pick_stamp());
		end
	endtask

	initial begin
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		frame_id = '0;
		length_code = '0;
		payload = '0;
		stamp_us = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		write_reg(REG_OVERWRITE, 48'd1);
		write_reg(REG_SESSION, '0);

		// directed: insertions, unchanged and changed hits, long length codes
		send_frame('0, 4'd0, '0, '0);
		send_frame(ID_MAX, 4'd8, BYTES_ALL, STAMP_MAX);
		send_frame('0, 4'd0, BYTES_ALL, 48'd5);
		send_frame('0, 4'd4, 64'h0000_0000_1122_3344, 48'd6);
		send_frame('0, 4'd4, 64'hAAAA_AAAA_1122_3344, 48'd7);
		send_frame('0, 4'd4, 64'h0000_0000_1155_3344, 48'd8);
		send_frame('0, 4'd15, 64'h8877_6655_1155_3344, 48'd9);
		send_frame('0, 4'd9, 64'h8877_6655_1155_3344, 48'd10);
		send_frame('0, 4'd8, 64'h8877_6655_1155_3344, 48'd11);
		send_frame('0, 4'd8, 64'h8877_6655_1155_3344, 48'd12);
		send_frame(ID_MAX, 4'd2, '0, 48'd13);
		send_frame(ID_MAX, 4'd8, 64'hFFFF_FFFF_FFFF_0000, 48'd14);
		send_frame(29'd1, 4'd3, 64'h00FF_0000_00AB_CDEF, 48'd15);
		send_frame(29'd1, 4'd8, 64'h0000_0000_00AB_CDEF, 48'd16);
		send_frame(29'h1000_0000, 4'd1, 64'h55, STAMP_MAX);
		settle();

		// relative time clamped at zero
		write_reg(REG_SESSION, STAMP_MAX);
		send_frame('0, 4'd8, 64'h8877_6655_1155_3344, STAMP_MAX);
		send_frame(ID_MAX, 4'd8, BYTES_ALL, '0);
		settle();
		write_reg(REG_SESSION, 48'h8000_0000_0000);
		send_frame(29'h1000_0000, 4'd1, 64'h55, 48'h7FFF_FFFF_FFFF);
		send_frame(29'h1000_0000, 4'd1, 64'h56, 48'h8000_0000_0001);
		settle();

		// a few identifiers back to back, then a wider pool
		write_reg(REG_SESSION, STAMP_W'({$urandom, $urandom}));
		build_pool(0, 40);
		repeat (60) send_tracked(4);
		repeat (110) send_tracked(40);
		settle();

		// more identifiers than table slots
		write_reg(REG_SESSION, '0);
		build_pool(40, 80);
		repeat (200) send_tracked(80);
		settle();

		// overwrite disabled
		write_reg(REG_OVERWRITE, 48'd0);
		write_reg(REG_SESSION, STAMP_W'({$urandom, $urandom}));
		repeat (80) send_tracked(80);
		settle();

		// overwrite back on
		write_reg(REG_OVERWRITE, 48'd1);
		write_reg(REG_SESSION, STAMP_W'({$urandom, $urandom}));
		build_pool(80, POOL_MAX);
		repeat (80) send_tracked(POOL_MAX);

		settle();
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/cit_pkg.sv
rtl/cit_ram.sv
rtl/cit_key_cam.sv
rtl/cit_update.sv
rtl/can_id_change_tracker.sv
tb/can_id_tracker_checker.sv
tb/tb.sv
